// ----- rtl/acir_pkg.sv -----
// ----------------------------------------------------------------------------
// acir_pkg: shared types and constants of the AC remote IR frame encoder
// Holds the frame template, protocol code tables, register map and the
// structs that pass between the front, the command queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package acir_pkg;

  localparam int unsigned FRAME_BYTES = 35;
  localparam int unsigned BYTE_IDX_W  = 6;

  // Register map, as word indexes on the configuration port.
  localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [2:0] REG_BIT_MARK     = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [2:0] REG_GAP          = 3'd5;

  localparam logic [11:0] RST_HEADER_MARK  = 12'd3650;
  localparam logic [11:0] RST_HEADER_SPACE = 12'd1623;
  localparam logic [11:0] RST_BIT_MARK     = 12'd428;
  localparam logic [11:0] RST_ZERO_SPACE   = 12'd428;
  localparam logic [11:0] RST_ONE_SPACE    = 12'd1280;
  localparam logic [14:0] RST_GAP          = 15'd29000;

  // Request kinds.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  // Frame bytes that depend on the requested state, and section ends.
  localparam logic [BYTE_IDX_W-1:0] BYTE_MODE  = 6'd21;
  localparam logic [BYTE_IDX_W-1:0] BYTE_TEMP  = 6'd22;
  localparam logic [BYTE_IDX_W-1:0] BYTE_FAN   = 6'd24;
  localparam logic [BYTE_IDX_W-1:0] SEC_A_LAST = 6'd7;
  localparam logic [BYTE_IDX_W-1:0] SEC_B_LAST = 6'd15;
  localparam logic [BYTE_IDX_W-1:0] SEC_C_LAST = 6'd34;

  // Sum of the fixed bytes of the third section; the variable bytes are
  // added to it when a frame is built.
  localparam logic [7:0] SEC_C_FIXED_SUM = 8'h38;

  localparam logic [7:0] TEMP_LOW  = 8'd10;
  localparam logic [7:0] TEMP_HIGH = 8'd32;

  localparam logic [1:0] SEC_A = 2'd0;
  localparam logic [1:0] SEC_B = 2'd1;
  localparam logic [1:0] SEC_C = 2'd2;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_PRE,
    SEG_GAP,
    SEG_HDR,
    SEG_BITS,
    SEG_TRAIL
  } seg_t;

  typedef struct packed {
    logic [11:0] header_mark;
    logic [11:0] header_space;
    logic [11:0] bit_mark;
    logic [11:0] zero_space;
    logic [11:0] one_space;
    logic [14:0] gap;
  } cfg_t;

  // One classified request as it travels through the command queue.
  typedef struct packed {
    logic       is_next;
    logic [7:0] mode_byte;
    logic [7:0] temp_byte;
    logic [7:0] fan_byte;
    logic [7:0] sum_byte;
  } cmd_t;

  typedef struct packed {
    logic        valid_res;
    logic [11:0] mark_us;
    logic [15:0] space_us;
    logic        last_pair;
  } res_t;

  // Fixed frame contents; the checksum bytes of the first two sections are
  // constant and already folded in.
  function automatic logic [7:0] frame_template(input logic [BYTE_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      6'd0:    b = 8'h11;
      6'd1:    b = 8'hDA;
      6'd2:    b = 8'h27;
      6'd4:    b = 8'hC5;
      6'd7:    b = 8'hD7;
      6'd8:    b = 8'h11;
      6'd9:    b = 8'hDA;
      6'd10:   b = 8'h27;
      6'd12:   b = 8'h42;
      6'd15:   b = 8'h54;
      6'd16:   b = 8'h11;
      6'd17:   b = 8'hDA;
      6'd18:   b = 8'h27;
      6'd21:   b = 8'h49;
      6'd22:   b = 8'h1E;
      6'd24:   b = 8'hB0;
      6'd27:   b = 8'h06;
      6'd28:   b = 8'h60;
      6'd31:   b = 8'hC0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] mode_code(input logic [2:0] op_mode);
    logic [2:0] c;
    case (op_mode)
      3'd1:    c = 3'd2;
      3'd2:    c = 3'd3;
      3'd3:    c = 3'd4;
      3'd4:    c = 3'd6;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] fan_code(input logic [1:0] fan_speed);
    logic [3:0] c;
    case (fan_speed)
      2'd1:    c = 4'd3;
      2'd2:    c = 4'd5;
      2'd3:    c = 4'd7;
      default: c = 4'hA;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/acir_in_if.sv -----
// ----------------------------------------------------------------------------
// acir_in_if: request channel
// Valid/ready channel that carries one start or next request.
// ----------------------------------------------------------------------------
`default_nettype none

interface acir_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic       power_on;
  logic [2:0] op_mode;
  logic [7:0] temp_celsius;
  logic [1:0] fan_speed;
  logic       swing_on;

  modport source (output valid, req_type, power_on, op_mode, temp_celsius,
                  fan_speed, swing_on, input ready);
  modport sink (input valid, req_type, power_on, op_mode, temp_celsius,
                fan_speed, swing_on, output ready);
endinterface

`default_nettype wire

// ----- rtl/acir_out_if.sv -----
// ----------------------------------------------------------------------------
// acir_out_if: result channel
// Valid/ready channel that carries one mark/space pair result.
// ----------------------------------------------------------------------------
`default_nettype none

interface acir_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [11:0] mark_us;
  logic [15:0] space_us;
  logic        last_pair;

  modport source (output valid, valid_res, mark_us, space_us, last_pair,
                  input ready);
  modport sink (input valid, valid_res, mark_us, space_us, last_pair,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/acir_front.sv -----
// ----------------------------------------------------------------------------
// acir_front: request classifier
// Accepts requests, and for a start builds the variable frame bytes and the
// checksum of the third section before queuing the command.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_front (
  acir_in_if.sink        in_chan,
  input  wire logic      q_full,
  output acir_pkg::cmd_t q_wr_data,
  output logic           q_push
);
  import acir_pkg::*;

  logic [7:0] temp_clamped;
  logic [7:0] mode_b;
  logic [7:0] temp_b;
  logic [7:0] fan_b;

  always_comb begin
    if (in_chan.temp_celsius < TEMP_LOW) begin
      temp_clamped = TEMP_LOW;
    end else if (in_chan.temp_celsius > TEMP_HIGH) begin
      temp_clamped = TEMP_HIGH;
    end else begin
      temp_clamped = in_chan.temp_celsius;
    end
    mode_b = {1'b0, mode_code(in_chan.op_mode), 1'b1, 2'b00, in_chan.power_on};
    temp_b = {temp_clamped[6:0], 1'b0};
    fan_b  = {fan_code(in_chan.fan_speed), {4{in_chan.swing_on}}};

    q_wr_data.is_next   = (in_chan.req_type == REQ_NEXT);
    q_wr_data.mode_byte = mode_b;
    q_wr_data.temp_byte = temp_b;
    q_wr_data.fan_byte  = fan_b;
    q_wr_data.sum_byte  = SEC_C_FIXED_SUM + mode_b + temp_b + fan_b;
  end

  assign in_chan.ready = !q_full;
  assign q_push        = in_chan.valid && !q_full;

endmodule

`default_nettype wire

// ----- rtl/acir_fifo.sv -----
// ----------------------------------------------------------------------------
// acir_fifo: command queue
// Two-entry queue between the classifier and the pair sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  acir_pkg::cmd_t      wr_data,
  input  wire logic           pop,
  output acir_pkg::cmd_t      rd_data,
  output logic                full,
  output logic                empty
);
  import acir_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/acir_back.sv -----
// ----------------------------------------------------------------------------
// acir_back: pair sequencer
// Walks the preamble, gap, headers, data bits and trailers of the frame and
// delivers one pair (empty when idle) per next command through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_back #(
  parameter int unsigned PREAMBLE_ZERO_BITS = 5
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  acir_pkg::cfg_t cfg,
  input  acir_pkg::cmd_t q_rd_data,
  input  wire logic      q_empty,
  output logic           q_pop,
  acir_out_if.source     out_chan
);
  import acir_pkg::*;

  localparam int unsigned PRE_W = $clog2(PREAMBLE_ZERO_BITS + 1);
  localparam logic [PRE_W-1:0] PRE_LAST = PRE_W'(PREAMBLE_ZERO_BITS - 1);

  seg_t                  seg_r, seg_nxt;
  logic [PRE_W-1:0]      pre_cnt_r, pre_cnt_nxt;
  logic [BYTE_IDX_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [2:0]            bit_idx_r, bit_idx_nxt;
  logic [1:0]            sec_r, sec_nxt;
  logic [7:0]            mode_byte_r, temp_byte_r, fan_byte_r, sum_byte_r;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r, res;
  logic [7:0]            cur_byte;
  logic [BYTE_IDX_W-1:0] sec_last;
  logic [15:0]           trail_space;
  logic                  load_frame;

  always_comb begin
    case (byte_idx_r)
      BYTE_MODE:  cur_byte = mode_byte_r;
      BYTE_TEMP:  cur_byte = temp_byte_r;
      BYTE_FAN:   cur_byte = fan_byte_r;
      SEC_C_LAST: cur_byte = sum_byte_r;
      default:    cur_byte = frame_template(byte_idx_r);
    endcase
    case (sec_r)
      SEC_A:   sec_last = SEC_A_LAST;
      SEC_B:   sec_last = SEC_B_LAST;
      default: sec_last = SEC_C_LAST;
    endcase
  end

  assign trail_space = {4'd0, cfg.zero_space} + {1'b0, cfg.gap};

  always_comb begin
    q_pop         = !q_empty && (!out_valid_r || out_chan.ready);
    load_frame    = q_pop && !q_rd_data.is_next;
    seg_nxt       = seg_r;
    pre_cnt_nxt   = pre_cnt_r;
    byte_idx_nxt  = byte_idx_r;
    bit_idx_nxt   = bit_idx_r;
    sec_nxt       = sec_r;
    res           = '0;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    if (load_frame) begin
      seg_nxt      = SEG_PRE;
      pre_cnt_nxt  = '0;
      byte_idx_nxt = '0;
      bit_idx_nxt  = '0;
      sec_nxt      = SEC_A;
    end else if (q_pop) begin
      out_valid_nxt = 1'b1;
      case (seg_r)
        SEG_PRE: begin
          res = '{valid_res: 1'b1, mark_us: cfg.bit_mark,
                  space_us: {4'd0, cfg.zero_space}, last_pair: 1'b0};
          pre_cnt_nxt = pre_cnt_r + PRE_W'(1);
          if (pre_cnt_r == PRE_LAST) begin
            seg_nxt = SEG_GAP;
          end
        end
        SEG_GAP: begin
          res = '{valid_res: 1'b1, mark_us: cfg.bit_mark,
                  space_us: trail_space, last_pair: 1'b0};
          seg_nxt = SEG_HDR;
        end
        SEG_HDR: begin
          res = '{valid_res: 1'b1, mark_us: cfg.header_mark,
                  space_us: {4'd0, cfg.header_space}, last_pair: 1'b0};
          seg_nxt = SEG_BITS;
        end
        SEG_BITS: begin
          res = '{valid_res: 1'b1, mark_us: cfg.bit_mark,
                  space_us: {4'd0, cur_byte[bit_idx_r] ? cfg.one_space
                                                       : cfg.zero_space},
                  last_pair: 1'b0};
          bit_idx_nxt = bit_idx_r + 3'd1;
          if (bit_idx_r == 3'd7) begin
            byte_idx_nxt = byte_idx_r + 6'd1;
            if (byte_idx_r == sec_last) begin
              seg_nxt = SEG_TRAIL;
            end
          end
        end
        SEG_TRAIL: begin
          res = '{valid_res: 1'b1, mark_us: cfg.bit_mark,
                  space_us: trail_space, last_pair: (sec_r == SEC_C)};
          if (sec_r == SEC_C) begin
            seg_nxt = SEG_IDLE;
          end else begin
            sec_nxt = sec_r + 2'd1;
            seg_nxt = SEG_HDR;
          end
        end
        default: begin
          // No frame in progress: an empty result.
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= SEG_IDLE;
      pre_cnt_r   <= '0;
      byte_idx_r  <= '0;
      bit_idx_r   <= '0;
      sec_r       <= SEC_A;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      pre_cnt_r   <= pre_cnt_nxt;
      byte_idx_r  <= byte_idx_nxt;
      bit_idx_r   <= bit_idx_nxt;
      sec_r       <= sec_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_frame) begin
      mode_byte_r <= q_rd_data.mode_byte;
      temp_byte_r <= q_rd_data.temp_byte;
      fan_byte_r  <= q_rd_data.fan_byte;
      sum_byte_r  <= q_rd_data.sum_byte;
    end
    if (q_pop && q_rd_data.is_next) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.valid_res = out_res_r.valid_res;
  assign out_chan.mark_us   = out_res_r.mark_us;
  assign out_chan.space_us  = out_res_r.space_us;
  assign out_chan.last_pair = out_res_r.last_pair;

endmodule

`default_nettype wire

// ----- rtl/ac_remote_ir_frame_encoder.sv -----
// A next request accepted on the request channel is written to a queue slot, then
// to the output register, from which its pair goes out on the result channel.
// Throughput: one request per cycle while results are taken, set by the single-pair step.
// A start request produces no result and restarts the frame at its first pair.
// Reset (rst_n low, synchronous) empties the queue, drops any frame in progress
// and restores the timing registers to their defaults.
// ----------------------------------------------------------------------------
// ac_remote_ir_frame_encoder: air-conditioner IR remote frame encoder
// Builds the 35-byte, three-section remote frame from the requested unit
// state and returns its mark/space timing sequence one pair per next request.
// ----------------------------------------------------------------------------
`default_nettype none

module ac_remote_ir_frame_encoder #(
  parameter int unsigned PREAMBLE_ZERO_BITS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  acir_in_if.sink          in_chan,
  acir_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import acir_pkg::*;

  // The design has three parts. The front classifies each request
  // transaction and, for a start, computes the three state-dependent frame
  // bytes and the checksum of the third section. Those values travel in a
  // two-entry command queue, so the front keeps accepting while the back
  // waits on a stalled result channel, until the queue is full. The back is
  // the pair sequencer: it keeps the frame bytes and a position made of a
  // segment state, a byte index and a bit index, and writes one pair, empty
  // when idle, per next command into its output register.

  cfg_t       cfg_r;
  cmd_t       q_wr_data;
  cmd_t       q_rd_data;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  logic       cfg_write;
  logic [2:0] reg_idx;

  // Configuration port: zero wait states, writes land at the access phase.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_mark  <= RST_HEADER_MARK;
      cfg_r.header_space <= RST_HEADER_SPACE;
      cfg_r.bit_mark     <= RST_BIT_MARK;
      cfg_r.zero_space   <= RST_ZERO_SPACE;
      cfg_r.one_space    <= RST_ONE_SPACE;
      cfg_r.gap          <= RST_GAP;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HEADER_MARK:  cfg_r.header_mark  <= pwdata[11:0];
        REG_HEADER_SPACE: cfg_r.header_space <= pwdata[11:0];
        REG_BIT_MARK:     cfg_r.bit_mark     <= pwdata[11:0];
        REG_ZERO_SPACE:   cfg_r.zero_space   <= pwdata[11:0];
        REG_ONE_SPACE:    cfg_r.one_space    <= pwdata[11:0];
        REG_GAP:          cfg_r.gap          <= pwdata[14:0];
        default: begin
          // Addresses past the register list are ignored.
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HEADER_MARK:  prdata = {20'd0, cfg_r.header_mark};
      REG_HEADER_SPACE: prdata = {20'd0, cfg_r.header_space};
      REG_BIT_MARK:     prdata = {20'd0, cfg_r.bit_mark};
      REG_ZERO_SPACE:   prdata = {20'd0, cfg_r.zero_space};
      REG_ONE_SPACE:    prdata = {20'd0, cfg_r.one_space};
      REG_GAP:          prdata = {17'd0, cfg_r.gap};
      default:          prdata = 32'd0;
    endcase
  end

  acir_front u_front (
    .in_chan   (in_chan),
    .q_full    (q_full),
    .q_wr_data (q_wr_data),
    .q_push    (q_push)
  );

  acir_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  acir_back #(
    .PREAMBLE_ZERO_BITS (PREAMBLE_ZERO_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_rd_data (q_rd_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ----- rtl/acir_checker.sv -----
// ----------------------------------------------------------------------------
// acir_checker: port-level checks of the IR frame encoder
// Watches the result channel for stall behavior, reset and result coding.
// ----------------------------------------------------------------------------
`default_nettype none

module acir_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        valid_res,
  input wire logic [11:0] mark_us,
  input wire logic [15:0] space_us,
  input wire logic        last_pair
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(valid_res) &&
      $stable(mark_us) && $stable(space_us) && $stable(last_pair))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An idle answer carries no timing.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !valid_res |-> mark_us == 12'd0 && space_us == 16'd0 && !last_pair)
    else $error("idle result carries timing");

  // The final pair is a real pair.
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_pair |-> valid_res)
    else $error("last pair flagged on idle result");

endmodule

bind ac_remote_ir_frame_encoder acir_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .valid_res (out_chan.valid_res),
  .mark_us   (out_chan.mark_us),
  .space_us  (out_chan.space_us),
  .last_pair (out_chan.last_pair)
);

`default_nettype wire

// ----- bench/acir_checker.sv -----
// ----------------------------------------------------------------------------
// acir_scoreboard: pair sequence predictor and scoreboard
// Watches the request, result and register channels of the frame encoder,
// keeps its own copy of the frame and timing registers, predicts every pair
// and compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module acir_scoreboard #(
  parameter int unsigned PRE_BITS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  acir_in_if               req_mon,
  acir_out_if              pair_mon,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int unsigned      mismatches,
  output int unsigned      pairs_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import acir_pkg::*;

  localparam int unsigned BYTES       = 35;
  localparam int unsigned SEC_A_BYTES = 8;
  localparam int unsigned SEC_B_BYTES = 8;
  localparam int unsigned SEC_C_BYTES = BYTES - SEC_A_BYTES - SEC_B_BYTES;
  localparam int unsigned SEC_A_PAIRS = SEC_A_BYTES * 8 + 2;
  localparam int unsigned SEC_B_PAIRS = SEC_B_BYTES * 8 + 2;
  localparam int unsigned SEC_C_PAIRS = SEC_C_BYTES * 8 + 2;
  localparam int unsigned FRAME_PAIRS = PRE_BITS + 1 + SEC_A_PAIRS + SEC_B_PAIRS + SEC_C_PAIRS;

  logic [11:0] hdr_mark, hdr_space, bit_mark, zero_space, one_space;
  logic [14:0] gap_len;
  logic [7:0]  frame_bytes [BYTES];
  int unsigned pair_idx;
  logic        frame_live;
  res_t        pairs_due [$];

  initial mismatches = 0;
  initial pairs_pending = 0;

  // Fixed frame contents; checksum bytes are left at zero and filled in later.
  function automatic logic [7:0] base_byte(input int unsigned idx);
    case (idx)
      0, 8, 16:   return 8'h11;
      1, 9, 17:   return 8'hDA;
      2, 10, 18:  return 8'h27;
      4:          return 8'hC5;
      12:         return 8'h42;
      21:         return 8'h49;
      22:         return 8'h1E;
      24:         return 8'hB0;
      27:         return 8'h06;
      28:         return 8'h60;
      31:         return 8'hC0;
      default:    return 8'h00;
    endcase
  endfunction

  function automatic logic [2:0] mode_nibble(input logic [2:0] m);
    case (m)
      3'd1:    return 3'd2;
      3'd2:    return 3'd3;
      3'd3:    return 3'd4;
      3'd4:    return 3'd6;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [3:0] fan_nibble(input logic [1:0] f);
    case (f)
      2'd1:    return 4'd3;
      2'd2:    return 4'd5;
      2'd3:    return 4'd7;
      default: return 4'hA;
    endcase
  endfunction

  function automatic logic [7:0] byte_sum(input int unsigned first, input int unsigned count);
    logic [7:0] acc;
    acc = 8'd0;
    for (int unsigned i = 0; i < count; i++) acc += frame_bytes[first + i];
    return acc;
  endfunction

  task automatic load_frame(input logic pwr, input logic [2:0] mode, input logic [7:0] temp,
                            input logic [1:0] fan, input logic sw);
    logic [7:0] t;
    t = (temp < 8'd10) ? 8'd10 : (temp > 8'd32) ? 8'd32 : temp;
    for (int unsigned i = 0; i < BYTES; i++) frame_bytes[i] = base_byte(i);
    frame_bytes[21] = {1'b0, mode_nibble(mode), 1'b1, 2'b00, pwr};
    frame_bytes[22] = {t[6:0], 1'b0};
    frame_bytes[24] = {fan_nibble(fan), sw ? 4'hF : 4'h0};
    frame_bytes[SEC_A_BYTES - 1] = byte_sum(0, SEC_A_BYTES - 1);
    frame_bytes[SEC_A_BYTES + SEC_B_BYTES - 1] = byte_sum(SEC_A_BYTES, SEC_B_BYTES - 1);
    frame_bytes[BYTES - 1] = byte_sum(SEC_A_BYTES + SEC_B_BYTES, SEC_C_BYTES - 1);
    pair_idx   = 0;
    frame_live = 1'b1;
  endtask

  task automatic advance_pair(output res_t r);
    int unsigned q, first, len, b;
    logic [11:0] mark;
    logic [15:0] space;
    r = '0;
    if (frame_live) begin
      mark  = bit_mark;
      space = {4'd0, zero_space};
      if (pair_idx == PRE_BITS) begin
        space = {4'd0, zero_space} + {1'b0, gap_len};
      end else if (pair_idx > PRE_BITS) begin
        q = pair_idx - PRE_BITS - 1;
        if (q < SEC_A_PAIRS) begin
          first = 0;
          len   = SEC_A_BYTES;
        end else if (q < SEC_A_PAIRS + SEC_B_PAIRS) begin
          first = SEC_A_BYTES;
          len   = SEC_B_BYTES;
          q     -= SEC_A_PAIRS;
        end else begin
          first = SEC_A_BYTES + SEC_B_BYTES;
          len   = SEC_C_BYTES;
          q     -= SEC_A_PAIRS + SEC_B_PAIRS;
        end
        if (q == 0) begin
          mark  = hdr_mark;
          space = {4'd0, hdr_space};
        end else if (q <= len * 8) begin
          b = q - 1;
          space = frame_bytes[first + b / 8][b % 8] ? {4'd0, one_space} : {4'd0, zero_space};
        end else begin
          space = {4'd0, zero_space} + {1'b0, gap_len};
        end
      end
      r.valid_res = 1'b1;
      r.mark_us   = mark;
      r.space_us  = space;
      r.last_pair = (pair_idx + 1 >= FRAME_PAIRS);
      if (r.last_pair) begin
        frame_live = 1'b0;
        pair_idx   = 0;
      end else begin
        pair_idx++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      hdr_mark   = RST_HEADER_MARK;
      hdr_space  = RST_HEADER_SPACE;
      bit_mark   = RST_BIT_MARK;
      zero_space = RST_ZERO_SPACE;
      one_space  = RST_ONE_SPACE;
      gap_len    = RST_GAP;
      pair_idx   = 0;
      frame_live = 1'b0;
      pairs_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_HEADER_MARK:  hdr_mark   = pwdata[11:0];
          REG_HEADER_SPACE: hdr_space  = pwdata[11:0];
          REG_BIT_MARK:     bit_mark   = pwdata[11:0];
          REG_ZERO_SPACE:   zero_space = pwdata[11:0];
          REG_ONE_SPACE:    one_space  = pwdata[11:0];
          REG_GAP:          gap_len    = pwdata[14:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_START) begin
          load_frame(req_mon.power_on, req_mon.op_mode, req_mon.temp_celsius,
                     req_mon.fan_speed, req_mon.swing_on);
        end else begin
          advance_pair(want);
          pairs_due.push_back(want);
        end
      end
      if (pair_mon.valid && pair_mon.ready) begin
        got = '{pair_mon.valid_res, pair_mon.mark_us, pair_mon.space_us, pair_mon.last_pair};
        if (pairs_due.size() == 0) begin
          $display("%0t: pair result with nothing expected, expected none, actual %0h",
                   $time, got);
          mismatches++;
        end else begin
          want = pairs_due.pop_front();
          check_field("valid_res", want.valid_res, got.valid_res);
          check_field("mark_us", want.mark_us, got.mark_us);
          check_field("space_us", want.space_us, got.space_us);
          check_field("last_pair", want.last_pair, got.last_pair);
        end
      end
    end
    pairs_pending = pairs_due.size();
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: frame encoder testbench top
// Drives start and next requests and register writes into the encoder,
// throttles the result channel, and leaves prediction and comparison to
// the scoreboard that sits beside the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acir_pkg::*;

  localparam int unsigned PRE_BITS     = 5;
  // Preamble, gap pair, then three sections of header, 35 data bytes and trailers.
  localparam int unsigned FRAME_PAIRS  = PRE_BITS + 1 + 3 * 2 + 35 * 8;
  localparam int unsigned ITEM_TARGET  = 1650;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned IDLE_PCT     = 8;
  localparam int unsigned CALM_FROM    = 900;
  localparam int unsigned CALM_TO      = 1200;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES  = 12;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Register slots past the end of the map; writes to them must be dropped.
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum int {
    SET_DISTINCT,
    SET_MAX,
    SET_ZERO,
    SET_RANDOM,
    SET_SPARE
  } setting_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned sent = 0;
  int unsigned cycles = 0;
  int unsigned mismatches;
  int unsigned pairs_pending;
  logic        held = 1'b0;

  acir_in_if  in_chan ();
  acir_out_if out_chan ();

  ac_remote_ir_frame_encoder #(
    .PREAMBLE_ZERO_BITS(PRE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  acir_scoreboard #(
    .PRE_BITS(PRE_BITS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (in_chan),
    .pair_mon      (out_chan),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .pairs_pending (pairs_pending)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or loses a transaction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Both sides run without any idling while the item count is inside this window.
  function automatic logic calm();
    return (sent >= CALM_FROM) && (sent < CALM_TO);
  endfunction

  // Offers one request and returns at the falling edge after the transaction.
  // All driving happens on falling edges, and ready is sampled on the rising
  // edge before the block updates its registers. Once the item budget is
  // spent, further offers are skipped.
  task automatic offer(input logic kind, input logic pwr, input logic [2:0] mode,
                       input logic [7:0] temp, input logic [1:0] fan, input logic sw);
    if (sent >= ITEM_TARGET) begin
      in_chan.valid = 1'b0;
      return;
    end
    while (!calm() && ($urandom_range(0, 99) < IDLE_PCT)) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid        = 1'b1;
    in_chan.req_type     = kind;
    in_chan.power_on     = pwr;
    in_chan.op_mode      = mode;
    in_chan.temp_celsius = temp;
    in_chan.fan_speed    = fan;
    in_chan.swing_on     = sw;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    sent++;
  endtask

  // A next request; the state fields are don't-care, so they carry noise.
  task automatic offer_next();
    offer(REQ_NEXT, 1'($urandom), 3'($urandom), 8'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // A start request with a random unit state. Temperatures are drawn so that
  // both clamping bounds and the full 8-bit range are exercised often.
  task automatic offer_start();
    logic [7:0] temp;
    case ($urandom_range(0, 3))
      0:       temp = 8'($urandom);
      1:       temp = 8'($urandom_range(0, 12));
      2:       temp = 8'($urandom_range(30, 40));
      default: temp = 8'($urandom_range(10, 32));
    endcase
    offer(REQ_START, 1'($urandom), 3'($urandom_range(0, 7)), temp, 2'($urandom), 1'($urandom));
  endtask

  // Waits until every predicted pair has come back, then gives a start that
  // may still sit in the block's queue time to drain before registers change.
  task automatic settle();
    in_chan.valid = 1'b0;
    while (pairs_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle until pready.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Each setting rewrites all six timing registers. The distinct setting
  // gives every pair kind its own value, so a pair from the wrong place in
  // the sequence cannot pass by coincidence. The maximum setting also sends
  // ones in the unused upper data bits, which must be masked off.
  task automatic apply_setting(input setting_e which);
    logic [31:0] v [6];
    case (which)
      SET_DISTINCT: v = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6};
      SET_MAX:      v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      SET_ZERO:     v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      default:      v = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    reg_write(REG_HEADER_MARK,  v[0]);
    reg_write(REG_HEADER_SPACE, v[1]);
    reg_write(REG_BIT_MARK,     v[2]);
    reg_write(REG_ZERO_SPACE,   v[3]);
    reg_write(REG_ONE_SPACE,    v[4]);
    reg_write(REG_GAP,          v[5]);
    if (which == SET_SPARE) begin
      reg_write(REG_SPARE_A, $urandom);
      reg_write(REG_SPARE_B, $urandom);
    end
  endtask

  // Result side: about eight stalled cycles in a hundred, none in the calm
  // window, and one long hold-off once the sender is well under way so that
  // the block's queue fills up and it has to stall its input.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && (sent >= HOLD_AT)) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      out_chan.ready = calm() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned phase_mark;
    int unsigned phase_no;

    // Every input is known from time zero, while reset is held low.
    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.req_type     = REQ_NEXT;
    in_chan.power_on     = 1'b0;
    in_chan.op_mode      = '0;
    in_chan.temp_celsius = '0;
    in_chan.fan_speed    = '0;
    in_chan.swing_on     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, run with the reset timing values. Next requests before
    // any start must come back with no pair.
    offer(REQ_NEXT, 1'b0, 3'd0, 8'd0, 2'd0, 1'b0);
    offer(REQ_NEXT, 1'b1, 3'd7, 8'hFF, 2'd3, 1'b1);
    // Lowest temperature, auto mode and fan, power and swing off.
    offer(REQ_START, 1'b0, 3'd0, 8'd0, 2'd0, 1'b0);
    offer_next();
    offer_next();
    // A start in the middle of a frame drops it and begins at the first pair.
    // Unknown mode 7 maps to auto; the top temperature clamps to 32.
    offer(REQ_START, 1'b1, 3'd7, 8'd255, 2'd3, 1'b1);
    offer_next();
    // Back-to-back starts walk every mode, fan speed and clamp boundary;
    // only the last one decides the frame that follows.
    offer(REQ_START, 1'b1, 3'd1, 8'd9,  2'd1, 1'b0);
    offer(REQ_START, 1'b0, 3'd2, 8'd10, 2'd2, 1'b1);
    offer(REQ_START, 1'b1, 3'd3, 8'd32, 2'd3, 1'b0);
    offer(REQ_START, 1'b0, 3'd4, 8'd33, 2'd0, 1'b1);
    offer(REQ_START, 1'b1, 3'd5, 8'd31, 2'd1, 1'b1);
    offer(REQ_START, 1'b0, 3'd6, 8'd11, 2'd2, 1'b0);
    repeat (6) offer_next();

    // Random part. Most traffic is whole frames, since the checksums and the
    // last sections are only reached after hundreds of next requests. The
    // rest are frames cut short by a new start and bursts of mixed requests.
    // Registers change between phases, always with the block drained.
    phase_mark = PHASE_ITEMS;
    phase_no   = 0;
    while (sent < ITEM_TARGET) begin
      if (sent >= phase_mark) begin
        settle();
        apply_setting(setting_e'(phase_no % 5));
        phase_no++;
        phase_mark += PHASE_ITEMS;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Whole frame, then possibly a few next requests against an idle block.
        offer_start();
        repeat (FRAME_PAIRS) offer_next();
        repeat ($urandom_range(0, 3)) offer_next();
      end else if (pick < 85) begin
        offer_start();
        repeat ($urandom_range(1, FRAME_PAIRS + 10)) offer_next();
      end else begin
        repeat ($urandom_range(3, 20)) begin
          if ($urandom_range(0, 1)) offer_start();
          else offer_next();
        end
      end
    end

    // Let the last results arrive, then a few more cycles for stragglers.
    in_chan.valid = 1'b0;
    while (pairs_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- ac_remote_ir_frame_encoder.f -----
rtl/acir_pkg.sv
rtl/acir_in_if.sv
rtl/acir_out_if.sv
rtl/acir_front.sv
rtl/acir_fifo.sv
rtl/acir_back.sv
rtl/ac_remote_ir_frame_encoder.sv
rtl/acir_checker.sv
bench/acir_checker.sv
bench/tb.sv
